### rtl/core/crc_data_framer_packetizer_macros.svh
// Assertion macros shared by the framer RTL.
`ifndef CRC_DATA_FRAMER_PACKETIZER_MACROS_SVH
`define CRC_DATA_FRAMER_PACKETIZER_MACROS_SVH

// Condition and consequence in the same cycle.
`define CDFP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition.
`define CDFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/crcdfp_pkg.sv
// Shared types and constants of the framer/packetizer.
package crcdfp_pkg;

   localparam int STREAM_W = 17;
   localparam int PKT_W    = 8;

   localparam logic        CMD_START  = 1'b0;
   localparam logic        CMD_DATA   = 1'b1;
   localparam logic [7:0]  KIND_ATTN  = 8'd1;
   localparam logic [7:0]  KIND_FIRST = 8'd2;
   localparam logic [7:0]  KIND_CONT  = 8'd3;
   localparam logic [7:0]  ATTN_BYTE  = 8'h01;
   localparam logic [15:0] CRC_SEED   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam logic [7:0]  TYPE_RESET = 8'd22;

   // one stuffed byte handed from front to back
   typedef struct packed {
      logic [7:0]          data_val;
      logic                start;       // first byte of a new message
      logic [STREAM_W-1:0] stream_len;  // total stuffed bytes, valid with start
      logic                last;        // last byte caused by the request
   } q_entry_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       packet_first;
      logic       message_end;
      logic       last;
   } rsp_item_type;

endpackage

### rtl/core/crcdfp_fifo.sv
// Small register FIFO used between front, back and the result port.
module crcdfp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/core/crcdfp_front.sv
// Front end: takes requests, tracks the open message and its CRC, emits stuffed bytes.
module crcdfp_front
   import crcdfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [7:0]  req_kind,
   input  logic [7:0]  req_seq,
   input  logic [15:0] req_msg_len,
   input  logic [7:0]  req_data_byte,
   output logic        q_push,
   output q_entry_type q_wr,
   input  logic        q_full
);

   localparam logic [2:0] ST_KIND    = 3'd0;
   localparam logic [2:0] ST_NKIND   = 3'd1;
   localparam logic [2:0] ST_SEQ     = 3'd2;
   localparam logic [2:0] ST_LEN_HI  = 3'd3;
   localparam logic [2:0] ST_LEN_LO  = 3'd4;  // payload byte for data requests
   localparam logic [2:0] ST_FCS_LO  = 3'd5;
   localparam logic [2:0] ST_FCS_HI  = 3'd6;

   function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic                busy_ff, busy_in;
   logic                attn_ff, attn_in;
   logic                data_ff, data_in;
   logic [2:0]          step_ff, step_in;
   logic [2:0]          last_ff, last_in;
   logic [7:0]          kind_ff, seq_ff, db_ff;
   logic [15:0]         len_ff;
   logic [STREAM_W-1:0] slen_ff, slen_in;
   logic [15:0]         payload_left_ff, payload_left_in;
   logic [15:0]         crc_ff, crc_in;

   logic       fire, at_end, accept;
   logic       is_start, is_attn, is_frame, is_data, has_work;
   logic [7:0] out_byte;
   logic       feed;

   assign fire   = busy_ff && !q_full;
   assign at_end = fire && (step_ff == last_ff);
   assign full   = busy_ff && !at_end;
   assign accept = push && !full;

   always_comb begin
      is_start = (req_cmd == CMD_START);
      is_attn  = is_start && (req_kind == KIND_ATTN);
      is_frame = is_start && (req_kind inside {KIND_FIRST, KIND_CONT});
      is_data  = (req_cmd == CMD_DATA) && (payload_left_ff != '0);
      has_work = is_attn || is_frame || is_data;
   end

   // stuffed byte of the current step
   always_comb begin
      out_byte = '0;
      if (attn_ff) begin
         out_byte = step_ff[0] ? ~ATTN_BYTE : ATTN_BYTE;
      end else begin
         case (step_ff)
            ST_KIND:   out_byte = kind_ff;
            ST_NKIND:  out_byte = ~kind_ff;
            ST_SEQ:    out_byte = seq_ff;
            ST_LEN_HI: out_byte = len_ff[15:8];
            ST_LEN_LO: out_byte = data_ff ? db_ff : len_ff[7:0];
            ST_FCS_LO: out_byte = ~crc_ff[7:0];
            ST_FCS_HI: out_byte = ~crc_ff[15:8];
            default:   out_byte = '0;
         endcase
      end
      feed = !attn_ff && (step_ff inside {ST_SEQ, ST_LEN_HI, ST_LEN_LO});
   end

   assign q_push          = fire;
   assign q_wr.data_val   = out_byte;
   assign q_wr.start      = !data_ff && (step_ff == ST_KIND);
   assign q_wr.stream_len = slen_ff;
   assign q_wr.last       = (step_ff == last_ff);

   always_comb begin
      busy_in         = busy_ff;
      attn_in         = attn_ff;
      data_in         = data_ff;
      step_in         = step_ff;
      last_in         = last_ff;
      slen_in         = slen_ff;
      payload_left_in = payload_left_ff;
      crc_in          = crc_ff;

      if (fire) begin
         step_in = step_ff + 3'd1;
         if (feed) begin
            crc_in = crc_byte(crc_ff, out_byte);
         end
      end
      if (at_end) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         busy_in = has_work;
         attn_in = is_attn;
         data_in = !is_start;
         if (is_start) begin
            crc_in          = CRC_SEED;
            payload_left_in = is_frame ? req_msg_len : '0;
            step_in         = ST_KIND;
            if (is_attn) begin
               last_in = ST_NKIND;
               slen_in = STREAM_W'(2);
            end else begin
               last_in = (req_msg_len == '0) ? ST_FCS_HI : ST_LEN_LO;
               slen_in = STREAM_W'(req_msg_len) + STREAM_W'(7);
            end
         end else if (is_data) begin
            payload_left_in = payload_left_ff - 16'd1;
            step_in         = ST_LEN_LO;
            last_in         = (payload_left_ff == 16'd1) ? ST_FCS_HI : ST_LEN_LO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         attn_ff         <= 1'b0;
         data_ff         <= 1'b0;
         step_ff         <= '0;
         last_ff         <= '0;
         slen_ff         <= '0;
         payload_left_ff <= '0;
         crc_ff          <= CRC_SEED;
      end else begin
         busy_ff         <= busy_in;
         attn_ff         <= attn_in;
         data_ff         <= data_in;
         step_ff         <= step_in;
         last_ff         <= last_in;
         slen_ff         <= slen_in;
         payload_left_ff <= payload_left_in;
         crc_ff          <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_work) begin
         kind_ff <= req_kind;
         seq_ff  <= req_seq;
         len_ff  <= req_msg_len;
         db_ff   <= req_data_byte;
      end
   end

endmodule

### rtl/core/crcdfp_back.sv
// Back end: cuts the stuffed stream into packets and inserts packet headers.
module crcdfp_back
   import crcdfp_pkg::*;
#(
   parameter int MAX_PACKET = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   type_code,
   input  q_entry_type  q_rd,
   input  logic         q_empty,
   output logic         q_pop,
   output logic         o_push,
   output rsp_item_type o_wr,
   input  logic         o_full
);

   localparam logic [1:0] PH_TYPE  = 2'd0;
   localparam logic [1:0] PH_LEN   = 2'd1;
   localparam logic [1:0] PH_CHECK = 2'd2;
   localparam logic [1:0] PH_BYTE  = 2'd3;

   logic [STREAM_W-1:0] stream_left_ff, stream_left_in;
   logic [PKT_W-1:0]    packet_left_ff, packet_left_in;
   logic [1:0]          phase_ff, phase_in;

   logic [STREAM_W-1:0] eff_stream;
   logic [PKT_W-1:0]    eff_packet;
   logic [PKT_W-1:0]    hdr_len;
   logic                need_hdr, fire;

   // a start entry restarts both counters before anything is sent
   always_comb begin
      eff_stream = q_rd.start ? q_rd.stream_len : stream_left_ff;
      eff_packet = q_rd.start ? '0 : packet_left_ff;
      need_hdr   = (eff_packet == '0) && (phase_ff != PH_BYTE);
      hdr_len    = (eff_stream > STREAM_W'(MAX_PACKET)) ? PKT_W'(MAX_PACKET)
                                                         : eff_stream[PKT_W-1:0];
   end

   always_comb begin
      o_wr.line_byte    = q_rd.data_val;
      o_wr.packet_first = 1'b0;
      o_wr.message_end  = (eff_stream == STREAM_W'(1));
      o_wr.last         = q_rd.last;
      if (need_hdr) begin
         o_wr.message_end = 1'b0;
         o_wr.last        = 1'b0;
         case (phase_ff)
            PH_TYPE: begin
               o_wr.line_byte    = type_code;
               o_wr.packet_first = 1'b1;
            end
            PH_LEN:   o_wr.line_byte = hdr_len;
            PH_CHECK: o_wr.line_byte = type_code ^ hdr_len;
            default:  o_wr.line_byte = type_code;
         endcase
      end
   end

   assign fire   = !q_empty && !o_full;
   assign o_push = fire;
   assign q_pop  = fire && !need_hdr;

   always_comb begin
      stream_left_in = stream_left_ff;
      packet_left_in = packet_left_ff;
      phase_in       = phase_ff;
      if (fire) begin
         if (need_hdr) begin
            phase_in = (phase_ff == PH_CHECK) ? PH_BYTE : phase_ff + 2'd1;
         end else begin
            phase_in       = PH_TYPE;
            stream_left_in = eff_stream - STREAM_W'(1);
            packet_left_in = ((eff_packet == '0) ? hdr_len : eff_packet) - PKT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_left_ff <= '0;
         packet_left_ff <= '0;
         phase_ff       <= PH_TYPE;
      end else begin
         stream_left_ff <= stream_left_in;
         packet_left_ff <= packet_left_in;
         phase_ff       <= phase_in;
      end
   end

endmodule

### rtl/core/crc_data_framer_packetizer.sv
// Framer/packetizer top level: front, stuffed-byte queue, back, result queue, CSR.
//
// Transmit framer with CRC-16/X.25 and packetizer. Requests go in through a
// push/full queue interface; line bytes come out through an empty/pop queue.
// The front writes the stuffed bytes of a request into the stuffed-byte queue,
// holding while it is full: a data byte yields 1 stuffed byte (3 when it closes
// the payload and the CRC follows), an attention start 2, a frame start 5 (7
// with an empty payload); the next request is taken in the cycle the previous
// one finishes. The back writes one line byte per cycle into the result queue
// while a stuffed byte waits and that queue has room, with the three header
// bytes before a packet's first stuffed byte, so about one data request per cycle
// between packet headers. A 4-entry queue between front and back and a
// 2-entry result queue let either side stall without stopping the other.
// The packet type register is written through csr_valid/csr_data (always
// ready) and should only change while no request is in flight.
`include "crc_data_framer_packetizer_macros.svh"

module crc_data_framer_packetizer
   import crcdfp_pkg::*;
#(
   parameter int MAX_PACKET = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [7:0]  req_kind,
   input  logic [7:0]  req_seq,
   input  logic [15:0] req_msg_len,
   input  logic [7:0]  req_data_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_line_byte,
   output logic        rsp_packet_first,
   output logic        rsp_message_end,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int Q_DEPTH = 4;
   localparam int O_DEPTH = 2;

   logic [7:0] packet_type_ff, packet_type_in;

   q_entry_type                     q_wr, q_rd;
   logic [$bits(q_entry_type)-1:0]  q_rd_vec;
   logic                            q_push, q_full, q_pop, q_empty;
   rsp_item_type                    o_wr, o_rd;
   logic [$bits(rsp_item_type)-1:0] o_rd_vec;
   logic                            o_push, o_full;
   logic                            hdr_push, end_flagged;

   assign csr_ready      = 1'b1;
   assign packet_type_in = (csr_valid && csr_ready) ? csr_data : packet_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_type_ff <= TYPE_RESET;
      end else begin
         packet_type_ff <= packet_type_in;
      end
   end

   crcdfp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_cmd       (req_cmd),
      .req_kind      (req_kind),
      .req_seq       (req_seq),
      .req_msg_len   (req_msg_len),
      .req_data_byte (req_data_byte),
      .q_push        (q_push),
      .q_wr          (q_wr),
      .q_full        (q_full)
   );

   crcdfp_fifo #(
      .WIDTH ($bits(q_entry_type)),
      .DEPTH (Q_DEPTH)
   ) u_stuff_q (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_vec),
      .empty   (q_empty)
   );

   assign q_rd = q_entry_type'(q_rd_vec);

   crcdfp_back #(
      .MAX_PACKET (MAX_PACKET)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .type_code (packet_type_ff),
      .q_rd      (q_rd),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .o_push    (o_push),
      .o_wr      (o_wr),
      .o_full    (o_full)
   );

   crcdfp_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (O_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (o_push),
      .wr_data (o_wr),
      .full    (o_full),
      .pop     (pop),
      .rd_data (o_rd_vec),
      .empty   (empty)
   );

   assign o_rd             = rsp_item_type'(o_rd_vec);
   assign rsp_line_byte    = o_rd.line_byte;
   assign rsp_packet_first = o_rd.packet_first;
   assign rsp_message_end  = o_rd.message_end;
   assign rsp_last         = o_rd.last;

   assign hdr_push    = o_push && o_wr.packet_first;
   assign end_flagged = o_wr.message_end || o_wr.last;

   `CDFP_ASSERT_SAME(a_pop_emits, q_pop, o_push, "stuffed byte consumed without a line byte")
   `CDFP_ASSERT_SAME(a_q_no_overrun, q_push, !q_full, "front wrote a full stuffed-byte queue")
   `CDFP_ASSERT_SAME(a_hdr_not_end, hdr_push, !end_flagged, "packet header flagged as end")
   `CDFP_ASSERT_NEXT(a_csr_write, csr_valid, packet_type_ff == $past(csr_data), "type write lost")

endmodule
